// ===== src/pbvp_pkg.sv =====
// Shared types and constants for the particle field gather and velocity push block.
`timescale 1ns / 1ps
`default_nettype none
package pbvp_pkg;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PUSH  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_X_SCALE     = 2'd0;
  localparam logic [1:0] REG_Y_SCALE     = 2'd1;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd3;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic        is_push;
    logic        write_ok;
    logic [6:0]  x_lo;
    logic [6:0]  x_hi;
    logic [6:0]  y_lo;
    logic [6:0]  y_hi;
    logic [15:0] wx;
    logic [15:0] wy;
    logic        oog;
    logic        last;
    logic [31:0] word0;
    logic [31:0] word1;
  } pbvp_entry_t;

  // Per-request data that rides along the arithmetic pipeline.
  typedef struct packed {
    logic        valid;
    logic        oog;
    logic        last;
    logic [15:0] wx;
    logic [15:0] wy;
    logic [31:0] vx;
    logic [31:0] vy;
  } pbvp_meta_t;

endpackage
`default_nettype wire

// ===== src/pbvp_front.sv =====
// Front end: accepts requests and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module pbvp_front #(
  parameter int GRID_X_MAX = 64,
  parameter int GRID_Y_MAX = 64
) (
  input  wire logic               start,
  input  wire logic               queue_full,
  input  wire logic               command,
  input  wire logic [5:0]         cell_x,
  input  wire logic [5:0]         cell_y,
  input  wire logic [31:0]        field_x_value,
  input  wire logic [31:0]        field_y_value,
  input  wire logic [21:0]        pos_x,
  input  wire logic [21:0]        pos_y,
  input  wire logic [31:0]        old_vx,
  input  wire logic [31:0]        old_vy,
  input  wire logic               last_particle,
  input  wire logic [6:0]         grid_width,
  input  wire logic [6:0]         grid_height,
  output logic                    push,
  output pbvp_pkg::pbvp_entry_t   entry
);

  logic [6:0] w_eff;
  logic [6:0] h_eff;
  logic [6:0] xl;
  logic [6:0] yl;

  // Clamp the grid size in use to at least 2 and to the storage that exists.
  always_comb begin
    if (grid_width < 7'd2) begin
      w_eff = 7'd2;
    end else if (int'(grid_width) > GRID_X_MAX) begin
      w_eff = 7'(GRID_X_MAX);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < 7'd2) begin
      h_eff = 7'd2;
    end else if (int'(grid_height) > GRID_Y_MAX) begin
      h_eff = 7'(GRID_Y_MAX);
    end else begin
      h_eff = grid_height;
    end
  end

  assign push = start && !queue_full;
  assign xl = {1'b0, pos_x[21:16]};
  assign yl = {1'b0, pos_y[21:16]};

  // Build the entry; a write reuses the index and word slots.
  always_comb begin
    entry = '0;
    entry.is_push = (command == pbvp_pkg::CMD_PUSH);
    entry.last = last_particle;
    if (command == pbvp_pkg::CMD_PUSH) begin
      entry.x_lo = xl;
      entry.y_lo = yl;
      entry.x_hi = (xl + 7'd1 == w_eff) ? 7'd0 : xl + 7'd1;
      entry.y_hi = (yl + 7'd1 == h_eff) ? 7'd0 : yl + 7'd1;
      entry.wx = pos_x[15:0];
      entry.wy = pos_y[15:0];
      entry.oog = (xl >= w_eff) || (yl >= h_eff);
      entry.word0 = old_vx;
      entry.word1 = old_vy;
    end else begin
      entry.x_lo = {1'b0, cell_x};
      entry.y_lo = {1'b0, cell_y};
      entry.write_ok = (int'(cell_x) < GRID_X_MAX) && (int'(cell_y) < GRID_Y_MAX);
      entry.word0 = field_x_value;
      entry.word1 = field_y_value;
    end
  end

endmodule
`default_nettype wire

// ===== src/pbvp_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module pbvp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire pbvp_pkg::pbvp_entry_t push_entry,
  input  wire logic                  pop,
  output pbvp_pkg::pbvp_entry_t      head,
  output logic                       empty,
  output logic                       full
);

  pbvp_pkg::pbvp_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop && !empty};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== src/pbvp_back.sv =====
// Back end: field memories, bilinear gather and velocity update pipeline.
`timescale 1ns / 1ps
`default_nettype none
module pbvp_back #(
  parameter int GRID_X_MAX = 64,
  parameter int GRID_Y_MAX = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  entry_valid,
  input  wire pbvp_pkg::pbvp_entry_t entry,
  input  wire logic [31:0]           x_scale,
  input  wire logic [31:0]           y_scale,
  output logic                       done,
  output logic [31:0]                new_vx,
  output logic [31:0]                new_vy,
  output logic                       out_of_grid,
  output logic                       last_out
);

  localparam int Depth = GRID_X_MAX * GRID_Y_MAX;
  localparam int AW = $clog2(Depth);

  // Copy A serves the low x column, copy B the high x column; word is {ey, ex}.
  logic [63:0] mem_a [Depth];
  logic [63:0] mem_b [Depth];

  logic [AW-1:0] addr_ll, addr_lh, addr_hl, addr_hh, addr_wr;
  logic          do_write;
  logic          do_push;

  assign addr_ll = AW'(int'(entry.x_lo) * GRID_Y_MAX + int'(entry.y_lo));
  assign addr_lh = AW'(int'(entry.x_lo) * GRID_Y_MAX + int'(entry.y_hi));
  assign addr_hl = AW'(int'(entry.x_hi) * GRID_Y_MAX + int'(entry.y_lo));
  assign addr_hh = AW'(int'(entry.x_hi) * GRID_Y_MAX + int'(entry.y_hi));
  assign addr_wr = addr_ll;
  assign do_write = entry_valid && !entry.is_push && entry.write_ok;
  assign do_push  = entry_valid && entry.is_push;

  // Stage 1: memory write, or registered reads of the four corners.
  logic [63:0] rd_ll, rd_lh, rd_hl, rd_hh;
  pbvp_pkg::pbvp_meta_t m1, m2, m3, m4, m5, m6, m7, m8;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_a[addr_wr] <= {entry.word1, entry.word0};
      mem_b[addr_wr] <= {entry.word1, entry.word0};
    end
    rd_ll <= mem_a[addr_ll];
    rd_lh <= mem_a[addr_lh];
    rd_hl <= mem_b[addr_hl];
    rd_hh <= mem_b[addr_hh];
  end

  // Arithmetic registers, index 0 for Ex and 1 for Ey.
  logic signed [31:0] s2_ll [2];
  logic signed [31:0] s2_hl [2];
  logic signed [32:0] s2_dl [2];
  logic signed [32:0] s2_dh [2];
  logic signed [31:0] s3_ll [2];
  logic signed [31:0] s3_hl [2];
  logic signed [49:0] s3_pl [2];
  logic signed [49:0] s3_ph [2];
  logic signed [33:0] s4_lo [2];
  logic signed [33:0] s4_hi [2];
  logic signed [33:0] s5_lo [2];
  logic signed [34:0] s5_dd [2];
  logic signed [33:0] s6_lo [2];
  logic signed [51:0] s6_q  [2];
  logic signed [32:0] s7_ei [2];
  logic signed [64:0] s8_pr [2];

  logic signed [49:0] rl [2];
  logic signed [49:0] rh [2];
  logic signed [51:0] rq [2];
  logic signed [35:0] ei_full [2];
  logic signed [64:0] rp [2];
  logic signed [31:0] scale [2];

  assign scale[0] = $signed(x_scale);
  assign scale[1] = $signed(y_scale);

  // Rounding adds half an LSB of the Q16 result, then floors.
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      rl[g] = s3_pl[g] + 50'sd32768;
      rh[g] = s3_ph[g] + 50'sd32768;
      rq[g] = s6_q[g] + 52'sd32768;
      ei_full[g] = s6_lo[g] + $signed(rq[g][51:16]);
      rp[g] = s8_pr[g] + 65'sd32768;
    end
  end

  // Stages 2 to 8 of the gather and scale.
  always_ff @(posedge clk) begin
    for (int g = 0; g < 2; g++) begin
      s2_ll[g] <= $signed(rd_ll[32*g +: 32]);
      s2_hl[g] <= $signed(rd_hl[32*g +: 32]);
      s2_dl[g] <= $signed(rd_lh[32*g +: 32]) - $signed(rd_ll[32*g +: 32]);
      s2_dh[g] <= $signed(rd_hh[32*g +: 32]) - $signed(rd_hl[32*g +: 32]);
      s3_ll[g] <= s2_ll[g];
      s3_hl[g] <= s2_hl[g];
      s3_pl[g] <= $signed({1'b0, m2.wy}) * s2_dl[g];
      s3_ph[g] <= $signed({1'b0, m2.wy}) * s2_dh[g];
      s4_lo[g] <= s3_ll[g] + $signed(rl[g][49:16]);
      s4_hi[g] <= s3_hl[g] + $signed(rh[g][49:16]);
      s5_lo[g] <= s4_lo[g];
      s5_dd[g] <= s4_hi[g] - s4_lo[g];
      s6_lo[g] <= s5_lo[g];
      s6_q[g]  <= $signed({1'b0, m5.wx}) * s5_dd[g];
      s7_ei[g] <= ei_full[g][32:0];
      s8_pr[g] <= s7_ei[g] * scale[g];
    end
  end

  // Request tags travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid <= 1'b0;
      m2.valid <= 1'b0;
      m3.valid <= 1'b0;
      m4.valid <= 1'b0;
      m5.valid <= 1'b0;
      m6.valid <= 1'b0;
      m7.valid <= 1'b0;
      m8.valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      m1.valid <= do_push;
      m2.valid <= m1.valid;
      m3.valid <= m2.valid;
      m4.valid <= m3.valid;
      m5.valid <= m4.valid;
      m6.valid <= m5.valid;
      m7.valid <= m6.valid;
      m8.valid <= m7.valid;
      done     <= m8.valid;
    end
    m1.oog  <= entry.oog;
    m1.last <= entry.last;
    m1.wx   <= entry.wx;
    m1.wy   <= entry.wy;
    m1.vx   <= entry.word0;
    m1.vy   <= entry.word1;
    m2[$bits(m2)-2:0] <= m1[$bits(m1)-2:0];
    m3[$bits(m3)-2:0] <= m2[$bits(m2)-2:0];
    m4[$bits(m4)-2:0] <= m3[$bits(m3)-2:0];
    m5[$bits(m5)-2:0] <= m4[$bits(m4)-2:0];
    m6[$bits(m6)-2:0] <= m5[$bits(m5)-2:0];
    m7[$bits(m7)-2:0] <= m6[$bits(m6)-2:0];
    m8[$bits(m8)-2:0] <= m7[$bits(m7)-2:0];
  end

  // Output register: add the rounded kick, or pass the velocity when off grid.
  always_ff @(posedge clk) begin
    out_of_grid <= m8.oog;
    last_out    <= m8.last;
    if (m8.oog) begin
      new_vx <= m8.vx;
      new_vy <= m8.vy;
    end else begin
      new_vx <= m8.vx + rp[0][47:16];
      new_vy <= m8.vy + rp[1][47:16];
    end
  end

endmodule
`default_nettype wire

// ===== src/pic_bilinear_velocity_push_top.sv =====
// Top level of the particle field gather and velocity push block.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// command selects a field cell write (cell_x, cell_y, field_x_value,
// field_y_value) or a particle push (pos_x, pos_y, old_vx, old_vy,
// last_particle). A write gives no result. A push gives one result on
// new_vx, new_vy, out_of_grid and last_out, marked by done for one cycle.
// A push passes the queue, the back-end pipeline and the output register before done.
// Throughput: one request per cycle; the back end reads both corner pairs of
// two duplicated field memories in the same cycle, so pushes stream at full rate.
// busy rises only if the two-entry queue between front and back fills,
// which a steady one-per-cycle stream does not do.
// Configuration: cfg_write, cfg_index and cfg_data write x_scale, y_scale,
// grid_width, grid_height; write only while no push is in flight.
// Reset sets both scales to 1.0 and the grid to 64 by 64; the field memories
// hold nothing until written. The receiver cannot stall: results are shown
// once and must be taken.
`timescale 1ns / 1ps
`default_nettype none
module pic_bilinear_velocity_push_top #(
  parameter int GRID_X_MAX = 64,
  parameter int GRID_Y_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [5:0]  cell_x,
  input  wire logic [5:0]  cell_y,
  input  wire logic [31:0] field_x_value,
  input  wire logic [31:0] field_y_value,
  input  wire logic [21:0] pos_x,
  input  wire logic [21:0] pos_y,
  input  wire logic [31:0] old_vx,
  input  wire logic [31:0] old_vy,
  input  wire logic        last_particle,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             done,
  output logic [31:0]      new_vx,
  output logic [31:0]      new_vy,
  output logic             out_of_grid,
  output logic             last_out
);

  logic [31:0] x_scale;
  logic [31:0] y_scale;
  logic [6:0]  grid_width;
  logic [6:0]  grid_height;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale     <= 32'd65536;
      y_scale     <= 32'd65536;
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        pbvp_pkg::REG_X_SCALE:     x_scale <= cfg_data;
        pbvp_pkg::REG_Y_SCALE:     y_scale <= cfg_data;
        pbvp_pkg::REG_GRID_WIDTH:  grid_width <= cfg_data[6:0];
        pbvp_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic                  q_push;
  logic                  q_full;
  logic                  q_empty;
  pbvp_pkg::pbvp_entry_t front_entry;
  pbvp_pkg::pbvp_entry_t q_head;

  assign busy = q_full;

  pbvp_front #(
    .GRID_X_MAX(GRID_X_MAX),
    .GRID_Y_MAX(GRID_Y_MAX)
  ) u_front (
    .start(start),
    .queue_full(q_full),
    .command(command),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .field_x_value(field_x_value),
    .field_y_value(field_y_value),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .old_vx(old_vx),
    .old_vy(old_vy),
    .last_particle(last_particle),
    .grid_width(grid_width),
    .grid_height(grid_height),
    .push(q_push),
    .entry(front_entry)
  );

  pbvp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_entry(front_entry),
    .pop(!q_empty),
    .head(q_head),
    .empty(q_empty),
    .full(q_full)
  );

  pbvp_back #(
    .GRID_X_MAX(GRID_X_MAX),
    .GRID_Y_MAX(GRID_Y_MAX)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .entry_valid(!q_empty),
    .entry(q_head),
    .x_scale(x_scale),
    .y_scale(y_scale),
    .done(done),
    .new_vx(new_vx),
    .new_vy(new_vy),
    .out_of_grid(out_of_grid),
    .last_out(last_out)
  );

endmodule
`default_nettype wire

// ===== tb/pbvp_checker.sv =====
// Checker for the particle field gather and velocity push block: predicts and compares results.
`timescale 1ns / 1ps
module pbvp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [31:0] field_x_value,
  input  logic [31:0] field_y_value,
  input  logic [21:0] pos_x,
  input  logic [21:0] pos_y,
  input  logic [31:0] old_vx,
  input  logic [31:0] old_vy,
  input  logic        last_particle,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [31:0] new_vx,
  input  logic [31:0] new_vy,
  input  logic        out_of_grid,
  input  logic        last_out,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic        oog;
    logic        last;
  } velocity_t;

  velocity_t   velocity_q[$];
  logic [31:0] ex_mem[0:4095];
  logic [31:0] ey_mem[0:4095];
  logic [31:0] x_factor;
  logic [31:0] y_factor;
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;

  initial fail_count = 0;

  // Product scaled down by 2^16, rounded to nearest with ties upward.
  function automatic longint round16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + round16(w * (b - a));
  endfunction

  function automatic int clamp_dim(logic [6:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  // Bilinear interpolation of one field component around the particle.
  function automatic longint interpolate(bit use_ey, int xl, int xh, int yl, int yh,
                                         longint wx, longint wy);
    longint ll, lh, hl, hh;
    if (use_ey) begin
      ll = longint'($signed(ey_mem[xl * 64 + yl]));
      lh = longint'($signed(ey_mem[xl * 64 + yh]));
      hl = longint'($signed(ey_mem[xh * 64 + yl]));
      hh = longint'($signed(ey_mem[xh * 64 + yh]));
    end else begin
      ll = longint'($signed(ex_mem[xl * 64 + yl]));
      lh = longint'($signed(ex_mem[xl * 64 + yh]));
      hl = longint'($signed(ex_mem[xh * 64 + yl]));
      hh = longint'($signed(ex_mem[xh * 64 + yh]));
    end
    return blend(blend(ll, lh, wy), blend(hl, hh, wy), wx);
  endfunction

  always @(posedge clk) begin
    velocity_t exp_v;
    int        delta;
    int        w, h, xl, yl, xh, yh;
    longint    vx, vy;
    if (rst) begin
      x_factor   = 32'h0001_0000;
      y_factor   = 32'h0001_0000;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      velocity_q.delete();
      pending <= 0;
    end else begin
      delta = 0;
      // Register writes.
      if (cfg_write) begin
        case (cfg_index)
          pbvp_pkg::REG_X_SCALE:     x_factor = cfg_data;
          pbvp_pkg::REG_Y_SCALE:     y_factor = cfg_data;
          pbvp_pkg::REG_GRID_WIDTH:  width_reg = cfg_data[6:0];
          pbvp_pkg::REG_GRID_HEIGHT: height_reg = cfg_data[6:0];
          default: ;
        endcase
      end
      // Compare a result against the oldest expectation.
      if (done) begin
        if (velocity_q.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          exp_v = velocity_q.pop_front();
          delta--;
          if (new_vx !== exp_v.vx) begin
            $error("new_vx expected %h got %h", exp_v.vx, new_vx);
            fail_count++;
          end
          if (new_vy !== exp_v.vy) begin
            $error("new_vy expected %h got %h", exp_v.vy, new_vy);
            fail_count++;
          end
          if (out_of_grid !== exp_v.oog) begin
            $error("out_of_grid expected %b got %b", exp_v.oog, out_of_grid);
            fail_count++;
          end
          if (last_out !== exp_v.last) begin
            $error("last_out expected %b got %b", exp_v.last, last_out);
            fail_count++;
          end
        end
      end
      // Accepted requests: update the field copy or predict a push.
      if (start && !busy) begin
        if (command == pbvp_pkg::CMD_WRITE) begin
          ex_mem[cell_x * 64 + cell_y] = field_x_value;
          ey_mem[cell_x * 64 + cell_y] = field_y_value;
        end else begin
          w  = clamp_dim(width_reg);
          h  = clamp_dim(height_reg);
          xl = int'(pos_x[21:16]);
          yl = int'(pos_y[21:16]);
          vx = longint'($signed(old_vx));
          vy = longint'($signed(old_vy));
          exp_v.oog = (xl >= w || yl >= h);
          if (!exp_v.oog) begin
            xh = (xl + 1 == w) ? 0 : xl + 1;
            yh = (yl + 1 == h) ? 0 : yl + 1;
            vx += round16(interpolate(1'b0, xl, xh, yl, yh, longint'(pos_x[15:0]),
                                      longint'(pos_y[15:0]))
                          * longint'($signed(x_factor)));
            vy += round16(interpolate(1'b1, xl, xh, yl, yh, longint'(pos_x[15:0]),
                                      longint'(pos_y[15:0]))
                          * longint'($signed(y_factor)));
          end
          exp_v.vx   = vx[31:0];
          exp_v.vy   = vy[31:0];
          exp_v.last = last_particle;
          velocity_q.push_back(exp_v);
          delta++;
        end
      end
      pending <= pending + delta;
    end
  end

endmodule

// ===== tb/tb_pic_bilinear_velocity_push_top.sv =====
// Testbench top for the particle field gather and velocity push block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_pic_bilinear_velocity_push_top;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic [31:0] field_x_value;
  logic [31:0] field_y_value;
  logic [21:0] pos_x;
  logic [21:0] pos_y;
  logic [31:0] old_vx;
  logic [31:0] old_vy;
  logic        last_particle;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  logic [31:0] new_vx;
  logic [31:0] new_vy;
  logic        out_of_grid;
  logic        last_out;
  int          fail_count;
  int          pending;
  int          cycles;

  // Stimulus-side view of the grid in use and of which cells hold data.
  int          grid_w;
  int          grid_h;
  bit          written[0:4095];
  bit          burst;

  pic_bilinear_velocity_push_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .cell_x(cell_x), .cell_y(cell_y), .field_x_value(field_x_value),
    .field_y_value(field_y_value), .pos_x(pos_x), .pos_y(pos_y),
    .old_vx(old_vx), .old_vy(old_vy), .last_particle(last_particle),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .new_vx(new_vx), .new_vy(new_vy), .out_of_grid(out_of_grid),
    .last_out(last_out)
  );

  pbvp_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .cell_x(cell_x), .cell_y(cell_y), .field_x_value(field_x_value),
    .field_y_value(field_y_value), .pos_x(pos_x), .pos_y(pos_y),
    .old_vx(old_vx), .old_vy(old_vy), .last_particle(last_particle),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .new_vx(new_vx), .new_vy(new_vy), .out_of_grid(out_of_grid),
    .last_out(last_out), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int clamp_dim(logic [6:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  // Present one request, after a random gap, and hold it until accepted.
  task automatic issue(input logic cmd, input logic [5:0] cx, input logic [5:0] cy,
                       input logic [31:0] fx, input logic [31:0] fy,
                       input logic [21:0] px, input logic [21:0] py,
                       input logic [31:0] vx, input logic [31:0] vy, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    command       <= cmd;
    cell_x        <= cx;
    cell_y        <= cy;
    field_x_value <= fx;
    field_y_value <= fy;
    pos_x         <= px;
    pos_y         <= py;
    old_vx        <= vx;
    old_vy        <= vy;
    last_particle <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_cell(input int x, input int y, input logic [31:0] fx,
                            input logic [31:0] fy);
    written[x * 64 + y] = 1'b1;
    issue(pbvp_pkg::CMD_WRITE, x[5:0], y[5:0], fx, fy, 22'($urandom), 22'($urandom),
          $urandom, $urandom, 1'($urandom));
  endtask

  task automatic fill_cell(input int x, input int y);
    if (!written[x * 64 + y]) write_cell(x, y, rand_word(), rand_word());
  endtask

  // A push; on the grid, the four surrounding cells are loaded first if they hold nothing yet.
  task automatic push_particle(input logic [21:0] px, input logic [21:0] py,
                               input logic last);
    int xl, yl, xh, yh;
    xl = int'(px[21:16]);
    yl = int'(py[21:16]);
    if (xl < grid_w && yl < grid_h) begin
      xh = (xl + 1 == grid_w) ? 0 : xl + 1;
      yh = (yl + 1 == grid_h) ? 0 : yl + 1;
      fill_cell(xl, yl);
      fill_cell(xl, yh);
      fill_cell(xh, yl);
      fill_cell(xh, yh);
    end
    issue(pbvp_pkg::CMD_PUSH, 6'($urandom), 6'($urandom), $urandom, $urandom, px, py,
          rand_word(), rand_word(), last);
  endtask

  // Stop sending and let every pending result and the pipeline tail pass.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] xs, input logic [31:0] ys,
                           input logic [31:0] wd, input logic [31:0] hd);
    cfg_write <= 1'b1;
    cfg_index <= pbvp_pkg::REG_X_SCALE;
    cfg_data  <= xs;
    @(posedge clk);
    cfg_index <= pbvp_pkg::REG_Y_SCALE;
    cfg_data  <= ys;
    @(posedge clk);
    cfg_index <= pbvp_pkg::REG_GRID_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= pbvp_pkg::REG_GRID_HEIGHT;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_write <= 1'b0;
    grid_w = clamp_dim(wd[6:0]);
    grid_h = clamp_dim(hd[6:0]);
  endtask

  // Random mix of pushes inside and outside the grid plus stray cell writes.
  task automatic random_phase(input int count);
    int           r;
    logic [5:0]   xi, yi;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        write_cell($urandom_range(0, 63), $urandom_range(0, 63), rand_word(), rand_word());
      end else begin
        xi = 6'($urandom_range(0, grid_w - 1));
        yi = 6'($urandom_range(0, grid_h - 1));
        if (r == 1 && grid_w < 64) xi = 6'($urandom_range(grid_w, 63));
        if (r == 2 && grid_h < 64) yi = 6'($urandom_range(grid_h, 63));
        push_particle({xi, rand_frac()}, {yi, rand_frac()}, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    command       <= pbvp_pkg::CMD_WRITE;
    cell_x        <= '0;
    cell_y        <= '0;
    field_x_value <= '0;
    field_y_value <= '0;
    pos_x         <= '0;
    pos_y         <= '0;
    old_vx        <= '0;
    old_vy        <= '0;
    last_particle <= 1'b0;
    cfg_write     <= 1'b0;
    cfg_index     <= pbvp_pkg::REG_X_SCALE;
    cfg_data      <= '0;
    grid_w = 64;
    grid_h = 64;
    burst  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme field values at the corners, wrap at the far edge.
    write_cell(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    write_cell(63, 63, 32'h8000_0000, 32'h7FFF_FFFF);
    write_cell(63, 0, 32'h0001_0000, 32'hFFFF_0000);
    write_cell(0, 63, 32'h0000_0000, 32'h0000_0001);
    push_particle(22'h00_0000, 22'h00_0000, 1'b0);
    push_particle(22'h3F_FFFF, 22'h3F_FFFF, 1'b1);
    push_particle({6'd63, 16'h8000}, {6'd0, 16'hFFFF}, 1'b0);
    push_particle({6'd0, 16'hFFFF}, {6'd63, 16'h0001}, 1'b1);
    // A push with its cell and field ports busy; its four cells hold data first.
    fill_cell(1, 1);
    fill_cell(1, 2);
    fill_cell(2, 1);
    fill_cell(2, 2);
    issue(pbvp_pkg::CMD_PUSH, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          {6'd1, 16'h0}, {6'd1, 16'h0}, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    random_phase(20);
    drain();

    // Smallest grid, extreme scales, positions off the grid.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'd2);
    push_particle(22'h3F_FFFF, 22'h00_0000, 1'b1);
    push_particle(22'h00_0000, 22'h3F_FFFF, 1'b0);
    push_particle({6'd2, 16'h0}, {6'd1, 16'hFFFF}, 1'b0);
    push_particle({6'd1, 16'hFFFF}, {6'd1, 16'hFFFF}, 1'b1);
    random_phase(60);
    drain();

    // Width below the minimum, height above the maximum, upper data bits set.
    configure(32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FF80, 32'h0000_007F);
    random_phase(50);
    drain();

    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd64);
    random_phase(40);
    drain();

    // Random settings, mostly small grids.
    for (int p = 0; p < 4; p++) begin
      configure(rand_word(), rand_word(),
                {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, 7'($urandom_range(0, 12))},
                p == 3 ? 32'($urandom) : 32'($urandom_range(0, 12)));
      random_phase(40);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pbvp_pkg.sv
src/pbvp_front.sv
src/pbvp_queue.sv
src/pbvp_back.sv
src/pic_bilinear_velocity_push_top.sv
tb/pbvp_checker.sv
tb/tb_pic_bilinear_velocity_push_top.sv
